// ===== rtl/bpi_pkg.sv =====
// Shared constants, types and helper functions for the box polynomial integral unit.
// Used by bpi_mul and box_polynomial_integral_unit; depends on nothing else.

package bpi_pkg;

  // Block sizing.
  localparam int DIMENSIONS    = 2;
  localparam int ORDER         = 2;
  localparam int FRACTION_BITS = 16;

  localparam int NPOW   = ORDER + 1;
  localparam int NMOM   = DIMENSIONS * NPOW;
  localparam int POW_W  = (ORDER > 0) ? $clog2(ORDER + 1) : 1;
  localparam int DIM_W  = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int ADDR_W = (NMOM > 1) ? $clog2(NMOM) : 1;
  localparam int DIV_W  = POW_W + 1;

  // Field widths of the input and result words.
  localparam int OP_W    = 2;
  localparam int AXIS_W  = 2;
  localparam int IN_W    = 32;
  localparam int RES_W   = 64;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_COEF  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Saturation limits.
  localparam logic [RES_W-1:0] SAT_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] SAT_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_SUB,
    ST_LD_DIV,
    ST_LD_WR,
    ST_LD_MA,
    ST_LD_WA,
    ST_LD_MB,
    ST_LD_WB,
    ST_CF_RD,
    ST_CF_MUL,
    ST_CF_WT,
    ST_CF_TERM,
    ST_CF_TW,
    ST_CF_ACC,
    ST_CF_OUT
  } state_t;

  // Request and response of the shared multiplier.
  typedef struct packed {
    logic start;
    logic frac_only;   // shift by FRACTION_BITS instead of twice that
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } mul_rsp_t;

  // A 64-bit value with its saturation flag.
  typedef struct packed {
    logic             sat;
    logic [RES_W-1:0] val;
  } sat_res_t;

  // Clamp an exact 65-bit sum or difference to 64 bits.
  function automatic sat_res_t sat_clamp(input logic [RES_W:0] s);
    sat_res_t r;
    r.sat = s[RES_W] ^ s[RES_W-1];
    if (r.sat) begin
      r.val = s[RES_W] ? SAT_MIN : SAT_MAX;
    end else begin
      r.val = s[RES_W-1:0];
    end
    return r;
  endfunction

  // Moment table address of one axis and power.
  function automatic logic [ADDR_W-1:0] mom_addr(input logic [DIM_W-1:0] ax,
                                                 input logic [POW_W-1:0] p);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(ax) * ADDR_W'(NPOW);
    return base + ADDR_W'(p);
  endfunction

endpackage

// ===== rtl/box_polynomial_integral_unit.sv =====
// Box polynomial integral unit: moment tables per axis and tensor-product integration.
// For each power, an interval word runs a subtract, the divider, a table write and two
// multiplications on the shared multiplier. A coefficient word reads the table once per axis
// and uses the shared multiplier for each axis beyond the first and once more for the term;
// at the end of a cell it also puts out the result word. One word at a time;
// a clear word is handled in the idle state. Reset is synchronous and active high.

module box_polynomial_integral_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bpi_pkg::OP_W-1:0]           operation,
  input  logic [bpi_pkg::AXIS_W-1:0]         axis,
  input  logic signed [bpi_pkg::IN_W-1:0]    lower_bound,
  input  logic signed [bpi_pkg::IN_W-1:0]    upper_bound,
  input  logic signed [bpi_pkg::IN_W-1:0]    coefficient,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bpi_pkg::RES_W-1:0]   cell_integral,
  output logic signed [bpi_pkg::RES_W-1:0]   total_mass,
  output logic                               overflow
);

  import bpi_pkg::*;

  localparam logic [DIM_W-1:0] LAST_DIM = DIM_W'(DIMENSIONS - 1);
  localparam logic [POW_W-1:0] LAST_POW = POW_W'(ORDER);

  state_t state;
  state_t state_next;

  // Control registers.
  logic [POW_W-1:0] pc [DIMENSIONS];
  logic [POW_W-1:0] pc_next [DIMENSIONS];
  logic             cell_done;
  logic [RES_W-1:0] cell_acc;
  logic [RES_W-1:0] mass_acc;
  logic             ovf_seen;
  logic [2:0]       div_cnt;

  // Payload registers.
  logic [RES_W-1:0] pa;
  logic [RES_W-1:0] pb;
  logic [RES_W-1:0] aq;
  logic [RES_W-1:0] bq;
  logic [POW_W-1:0] k;
  logic [DIM_W-1:0] ax;
  logic [DIM_W-1:0] idx;
  logic [RES_W-1:0] prod;
  logic [RES_W-1:0] term;
  logic [RES_W-1:0] coef_ext;
  logic [RES_W-1:0] dvd;
  logic [RES_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic             q_neg;

  // Combinational helpers.
  logic             accept;
  logic             axis_ok;
  sat_res_t         diff;
  sat_res_t         cell_sum;
  sat_res_t         mass_sum;
  logic [DIV_W-1:0] dvsr;
  logic [DIV_W-1:0] rem_next;
  logic [7:0]       q8;
  logic [DIV_W:0]   dstep;
  logic             out_free;

  // Moment table and multiplier connections.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [RES_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [RES_W-1:0]  ram_rdata;
  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;
  logic [RES_W-1:0]  mul_x;
  logic [RES_W-1:0]  mul_y;
  logic [RES_W-1:0]  mul_res;

  bpi_ram #(
    .WIDTH (RES_W),
    .DEPTH (NMOM)
  ) u_moments (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpi_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .req    (mul_req),
    .x      (mul_x),
    .y      (mul_y),
    .rsp    (mul_rsp),
    .result (mul_res)
  );

  assign accept   = in_valid && in_ready;
  assign axis_ok  = (3'(axis) < 3'(DIMENSIONS));
  assign out_free = !out_valid || out_ready;

  // Saturating subtract of the powers, and the two accumulations.
  assign diff     = sat_clamp({pb[RES_W-1], pb} - {pa[RES_W-1], pa});
  assign cell_sum = sat_clamp({cell_acc[RES_W-1], cell_acc} + {term[RES_W-1], term});
  assign mass_sum = sat_clamp({mass_acc[RES_W-1], mass_acc} + {cell_acc[RES_W-1], cell_acc});

  // Eight restoring division steps by the small divisor k + 1.
  assign dvsr = DIV_W'(k) + DIV_W'(1);
  always_comb begin
    rem_next = rem;
    q8       = '0;
    dstep    = '0;
    for (int i = 0; i < 8; i++) begin
      dstep = {rem_next, dvd[RES_W-1-i]};
      if (dstep >= {1'b0, dvsr}) begin
        rem_next = DIV_W'(dstep - {1'b0, dvsr});
        q8[7-i]  = 1'b1;
      end else begin
        rem_next = dstep[DIV_W-1:0];
      end
    end
  end

  // Multi-index counter, last axis fastest.
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int d = DIMENSIONS - 1; d >= 0; d--) begin
      pc_next[d] = pc[d];
      if (carry) begin
        if (pc[d] == LAST_POW) begin
          pc_next[d] = '0;
        end else begin
          pc_next[d] = pc[d] + POW_W'(1);
          carry      = 1'b0;
        end
      end
    end
    cell_done = carry;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_LOAD && axis_ok) begin
            state_next = ST_LD_SUB;
          end else if (operation == OP_COEF) begin
            state_next = ST_CF_RD;
          end
        end
      end
      ST_LD_SUB: state_next = ST_LD_DIV;
      ST_LD_DIV: begin
        if (div_cnt == 3'd7) begin
          state_next = ST_LD_WR;
        end
      end
      ST_LD_WR: state_next = ST_LD_MA;
      ST_LD_MA: state_next = ST_LD_WA;
      ST_LD_WA: begin
        if (mul_rsp.done) begin
          state_next = ST_LD_MB;
        end
      end
      ST_LD_MB: state_next = ST_LD_WB;
      ST_LD_WB: begin
        if (mul_rsp.done) begin
          state_next = (k == LAST_POW) ? ST_IDLE : ST_LD_SUB;
        end
      end
      ST_CF_RD: state_next = ST_CF_MUL;
      ST_CF_MUL: begin
        if (idx != '0) begin
          state_next = ST_CF_WT;
        end else begin
          state_next = (idx == LAST_DIM) ? ST_CF_TERM : ST_CF_RD;
        end
      end
      ST_CF_WT: begin
        if (mul_rsp.done) begin
          state_next = (idx == LAST_DIM) ? ST_CF_TERM : ST_CF_RD;
        end
      end
      ST_CF_TERM: state_next = ST_CF_TW;
      ST_CF_TW: begin
        if (mul_rsp.done) begin
          state_next = ST_CF_ACC;
        end
      end
      ST_CF_ACC: state_next = cell_done ? ST_CF_OUT : ST_IDLE;
      ST_CF_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, table port and multiplier request.
  always_comb begin
    in_ready          = (state == ST_IDLE);
    ram_we            = (state == ST_LD_WR);
    ram_waddr         = mom_addr(ax, k);
    ram_wdata         = q_neg ? (~quo + 64'd1) : quo;
    ram_raddr         = mom_addr(idx, pc[idx]);
    mul_req.start     = 1'b0;
    mul_req.frac_only = 1'b0;
    mul_x             = prod;
    mul_y             = ram_rdata;
    unique case (state)
      ST_LD_MA: begin
        mul_req.start = 1'b1;
        mul_x         = pa;
        mul_y         = aq;
      end
      ST_LD_MB: begin
        mul_req.start = 1'b1;
        mul_x         = pb;
        mul_y         = bq;
      end
      ST_CF_MUL: begin
        mul_req.start = (idx != '0);
      end
      ST_CF_TERM: begin
        mul_req.start     = 1'b1;
        mul_req.frac_only = 1'b1;
        mul_x             = coef_ext;
        mul_y             = prod;
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  // Control state, accumulators and the result word's valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cell_acc  <= '0;
      mass_acc  <= '0;
      ovf_seen  <= 1'b0;
      out_valid <= 1'b0;
      div_cnt   <= '0;
      for (int d = 0; d < DIMENSIONS; d++) begin
        pc[d] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_CF_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_LD_DIV) begin
        div_cnt <= div_cnt + 3'd1;
      end else begin
        div_cnt <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && operation == OP_CLEAR) begin
            mass_acc <= '0;
          end
        end
        ST_LD_SUB: begin
          if (diff.sat) begin
            ovf_seen <= 1'b1;
          end
        end
        ST_LD_WA, ST_LD_WB, ST_CF_WT, ST_CF_TW: begin
          if (mul_rsp.done && mul_rsp.sat) begin
            ovf_seen <= 1'b1;
          end
        end
        ST_CF_ACC: begin
          cell_acc <= cell_sum.val;
          if (cell_sum.sat) begin
            ovf_seen <= 1'b1;
          end
          for (int d = 0; d < DIMENSIONS; d++) begin
            pc[d] <= pc_next[d];
          end
        end
        ST_CF_OUT: begin
          if (out_free) begin
            mass_acc <= mass_sum.val;
            cell_acc <= '0;
            ovf_seen <= 1'b0;
          end
        end
        default: begin
          ovf_seen <= ovf_seen;
        end
      endcase
    end
  end

  // Payload registers: powers, divider, product chain and the result word.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        aq       <= RES_W'($signed(lower_bound)) << FRACTION_BITS;
        bq       <= RES_W'($signed(upper_bound)) << FRACTION_BITS;
        pa       <= RES_W'($signed(lower_bound)) << FRACTION_BITS;
        pb       <= RES_W'($signed(upper_bound)) << FRACTION_BITS;
        ax       <= axis[DIM_W-1:0];
        k        <= '0;
        idx      <= '0;
        coef_ext <= RES_W'($signed(coefficient));
      end
      ST_LD_SUB: begin
        q_neg <= diff.val[RES_W-1];
        dvd   <= diff.val[RES_W-1] ? (~diff.val + 64'd1) : diff.val;
        rem   <= '0;
      end
      ST_LD_DIV: begin
        dvd <= dvd << 8;
        quo <= {quo[RES_W-9:0], q8};
        rem <= rem_next;
      end
      ST_LD_WA: begin
        if (mul_rsp.done) begin
          pa <= mul_res;
        end
      end
      ST_LD_WB: begin
        if (mul_rsp.done) begin
          pb <= mul_res;
          k  <= k + POW_W'(1);
        end
      end
      ST_CF_MUL: begin
        if (idx == '0) begin
          prod <= ram_rdata;
          idx  <= idx + DIM_W'(1);
        end
      end
      ST_CF_WT: begin
        if (mul_rsp.done) begin
          prod <= mul_res;
          idx  <= idx + DIM_W'(1);
        end
      end
      ST_CF_TW: begin
        if (mul_rsp.done) begin
          term <= mul_res;
        end
      end
      ST_CF_OUT: begin
        if (out_free) begin
          cell_integral <= cell_acc;
          total_mass    <= mass_sum.val;
          overflow      <= ovf_seen || mass_sum.sat;
        end
      end
      default: begin
        prod <= prod;
      end
    endcase
  end

`ifndef SYNTHESIS
  // The multiplier is only started while it is idle.
  assert property (@(posedge clk) disable iff (rst) mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  // A multiplier result only arrives while the sequencer waits for one.
  assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == ST_LD_WA || state == ST_LD_WB ||
                      state == ST_CF_WT || state == ST_CF_TW))
    else $error("multiplier result arrived outside a wait state");

  // A result word only appears after the end of a cell.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_CF_OUT)
    else $error("result word raised outside the end of a cell");
`endif

endmodule

// ===== rtl/bpi_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing else.

module bpi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 6
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bpi_mul.sv =====
// Shared 64 x 64 signed multiplier with rounding shift and saturation.
// One 32 x 32 partial product per cycle; depends on bpi_pkg.

module bpi_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  bpi_pkg::mul_req_t             req,
  input  logic [bpi_pkg::RES_W-1:0]     x,
  input  logic [bpi_pkg::RES_W-1:0]     y,
  output bpi_pkg::mul_rsp_t             rsp,
  output logic [bpi_pkg::RES_W-1:0]     result
);

  import bpi_pkg::*;

  localparam int SH_HI = 2 * FRACTION_BITS;
  localparam int SH_LO = FRACTION_BITS;
  localparam int PW    = 2 * RES_W;

  logic          busy;
  logic          done;
  logic          sat;
  logic [2:0]    cnt;
  logic          pp_valid;
  logic [1:0]    pp_w;
  logic [63:0]   pp;
  logic          neg;
  logic          frac_only;
  logic [63:0]   ux;
  logic [63:0]   uy;
  logic [PW-1:0] acc;

  logic [PW-1:0]  shifted;
  logic [63:0]    lim;
  logic           over;
  logic [31:0]    x_part;
  logic [31:0]    y_part;

  // Operand halves picked by the step counter.
  assign x_part = cnt[1] ? ux[63:32] : ux[31:0];
  assign y_part = cnt[0] ? uy[63:32] : uy[31:0];

  // Final shift, range check and sign.
  always_comb begin
    shifted = frac_only ? (acc >> SH_LO) : (acc >> SH_HI);
    lim     = neg ? SAT_MIN : SAT_MAX;
    over    = (|shifted[PW-1:RES_W]) || (shifted[RES_W-1:0] > lim);
  end

  // Control: busy, step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      cnt      <= '0;
      pp_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        pp_valid <= 1'b0;
      end else if (busy) begin
        cnt      <= cnt + 3'd1;
        pp_valid <= (cnt < 3'd4);
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitudes, partial products and the 128-bit accumulator.
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg       <= x[RES_W-1] ^ y[RES_W-1];
      ux        <= x[RES_W-1] ? (~x + 64'd1) : x;
      uy        <= y[RES_W-1] ? (~y + 64'd1) : y;
      frac_only <= req.frac_only;
      acc       <= req.frac_only ? (PW'(1) << (SH_LO - 1)) : (PW'(1) << (SH_HI - 1));
    end else if (busy) begin
      pp   <= x_part * y_part;
      pp_w <= 2'(cnt[1]) + 2'(cnt[0]);
      if (pp_valid) begin
        acc <= acc + ({64'd0, pp} << (32 * pp_w));
      end
      if (cnt == 3'd5) begin
        sat <= over;
        if (over) begin
          result <= neg ? SAT_MIN : SAT_MAX;
        end else begin
          result <= neg ? (~shifted[RES_W-1:0] + 64'd1) : shifted[RES_W-1:0];
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.sat  = sat;

endmodule

// ===== tb/sv/box_polynomial_integral_unit_tb.sv =====
// Self-checking testbench for the box polynomial integral unit.
// It predicts every cell integral within the bench and compares each result word with that prediction.
// Depends on bpi_pkg and box_polynomial_integral_unit.

module box_polynomial_integral_unit_tb;
  import bpi_pkg::*;

  // The one spare operation code. The block ignores it.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int CELL_TERMS = NPOW ** DIMENSIONS;
  localparam int TARGET_WORDS = 1300;
  localparam longint WIDE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint WIDE_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [IN_W-1:0] Q_ONE = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [OP_W-1:0] operation;
  logic [AXIS_W-1:0] axis;
  logic signed [IN_W-1:0] lower_bound;
  logic signed [IN_W-1:0] upper_bound;
  logic signed [IN_W-1:0] coefficient;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [RES_W-1:0] cell_integral;
  logic signed [RES_W-1:0] total_mass;
  logic overflow;

  // A predicted result word.
  typedef struct {
    longint cell_int;
    longint mass;
    logic   ovf;
  } integral_word_t;

  integral_word_t pending_integrals[$];

  // The bench's own copy of the block state.
  longint moments [NMOM];
  logic [2:0] power_pos [DIMENSIONS];
  longint cell_sum;
  longint mass_sum;
  logic sat_seen;

  int mismatches;
  int integrals_checked;
  int words_sent;
  int words_ignored;
  int rx_hold;
  logic idle_on;

  box_polynomial_integral_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .axis          (axis),
    .lower_bound   (lower_bound),
    .upper_bound   (upper_bound),
    .coefficient   (coefficient),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cell_integral (cell_integral),
    .total_mass    (total_mass),
    .overflow      (overflow)
  );

  // Clock with a period of 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Exact 65-bit sum or difference, clamped to 64 bits.
  function automatic longint clamp_add(longint x, longint y, logic subtract);
    logic [64:0] s;
    if (subtract) begin
      s = {x[63], x} - {y[63], y};
    end else begin
      s = {x[63], x} + {y[63], y};
    end
    if (s[64] != s[63]) begin
      sat_seen = 1'b1;
      return s[64] ? WIDE_MIN : WIDE_MAX;
    end
    return longint'(s[63:0]);
  endfunction

  // Full product shifted right, rounded half away from zero, then clamped.
  function automatic longint round_product(longint x, longint y, int shift);
    logic neg;
    logic [63:0] ux;
    logic [63:0] uy;
    logic [127:0] full;
    logic [127:0] limit;
    neg = (x < 0) != (y < 0);
    ux = (x < 0) ? -x : x;
    uy = (y < 0) ? -y : y;
    full = {64'd0, ux} * {64'd0, uy};
    if (shift > 0) begin
      full = full + (128'd1 << (shift - 1));
    end
    full = full >> shift;
    limit = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
    if (full > limit) begin
      sat_seen = 1'b1;
      return neg ? WIDE_MIN : WIDE_MAX;
    end
    return neg ? -longint'(full[63:0]) : longint'(full[63:0]);
  endfunction

  // Store the moments (b^(k+1) - a^(k+1)) / (k+1) of one axis.
  // The power after the last moment is still formed, and it can saturate.
  function automatic void load_moments(int ax, logic signed [IN_W-1:0] a,
                                       logic signed [IN_W-1:0] b);
    longint aq;
    longint bq;
    longint pa;
    longint pb;
    longint diff;
    int k;
    aq = longint'(a) <<< FRACTION_BITS;
    bq = longint'(b) <<< FRACTION_BITS;
    pa = aq;
    pb = bq;
    for (k = 0; k < NPOW; k++) begin
      diff = clamp_add(pb, pa, 1'b1);
      moments[ax * NPOW + k] = diff / longint'(k + 1);
      pa = round_product(pa, aq, 2 * FRACTION_BITS);
      pb = round_product(pb, bq, 2 * FRACTION_BITS);
    end
  endfunction

  // Apply one accepted word to the state copy, and queue a result at the end of a cell.
  function automatic void integrate_word(logic [OP_W-1:0] op, logic [AXIS_W-1:0] ax,
                                         logic signed [IN_W-1:0] a,
                                         logic signed [IN_W-1:0] b,
                                         logic signed [IN_W-1:0] c);
    longint prod;
    longint term;
    logic carry;
    int d;
    integral_word_t res;
    if (op == OP_LOAD) begin
      if (ax < DIMENSIONS) begin
        load_moments(int'(ax), a, b);
      end
    end else if (op == OP_CLEAR) begin
      mass_sum = 0;
    end else if (op == OP_COEF) begin
      prod = longint'(1) <<< (2 * FRACTION_BITS);
      for (d = 0; d < DIMENSIONS; d++) begin
        prod = round_product(prod, moments[d * NPOW + power_pos[d]], 2 * FRACTION_BITS);
      end
      term = round_product(longint'(c), prod, FRACTION_BITS);
      cell_sum = clamp_add(cell_sum, term, 1'b0);
      // Step the multi-index with the last axis fastest.
      carry = 1'b1;
      for (d = DIMENSIONS - 1; d >= 0 && carry; d--) begin
        if (power_pos[d] < ORDER) begin
          power_pos[d]++;
          carry = 1'b0;
        end else begin
          power_pos[d] = '0;
        end
      end
      if (carry) begin
        mass_sum = clamp_add(mass_sum, cell_sum, 1'b0);
        res.cell_int = cell_sum;
        res.mass = mass_sum;
        res.ovf = sat_seen;
        pending_integrals.push_back(res);
        cell_sum = 0;
        sat_seen = 1'b0;
      end
    end
  endfunction

  // Check each result word against the oldest prediction, then apply the accepted input word.
  always @(posedge clk) begin : integral_check
    integral_word_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_integrals.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, cell %h mass %h overflow %b",
                   $time, cell_integral, total_mass, overflow);
        end else begin
          want = pending_integrals.pop_front();
          integrals_checked++;
          if (cell_integral !== want.cell_int) begin
            mismatches++;
            $display("%0t: cell_integral expected %h, got %h", $time, want.cell_int,
                     cell_integral);
          end
          if (total_mass !== want.mass) begin
            mismatches++;
            $display("%0t: total_mass expected %h, got %h", $time, want.mass, total_mass);
          end
          if (overflow !== want.ovf) begin
            mismatches++;
            $display("%0t: overflow expected %b, got %b", $time, want.ovf, overflow);
          end
        end
      end
      if (in_valid && in_ready) begin
        integrate_word(operation, axis, lower_bound, upper_bound, coefficient);
      end
    end
  end

  // Result side: a counted hold-off when one is requested, otherwise random stalls while idle cycles are on.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_ready <= !idle_on || ($urandom_range(99) >= 14);
    end
  end

  // Offer one word, with random idle cycles first when they are on, and wait until it is taken.
  task automatic send_word(logic [OP_W-1:0] op, logic [AXIS_W-1:0] ax,
                           logic [IN_W-1:0] a, logic [IN_W-1:0] b, logic [IN_W-1:0] c);
    while (idle_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    axis <= ax;
    lower_bound <= a;
    upper_bound <= b;
    coefficient <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_SPARE || (op == OP_LOAD && ax >= DIMENSIONS)) begin
      words_ignored++;
    end else begin
      words_sent++;
    end
  endtask

  // A Q16.16 value: mostly within 16 units of zero, sometimes the whole range or an extreme.
  function automatic logic [IN_W-1:0] pick_q16();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel == 0) begin
      return 32'h7FFF_FFFF;
    end else if (sel == 1) begin
      return 32'h8000_0000;
    end else if (sel < 4) begin
      return $urandom;
    end
    return $urandom_range(32'h0020_0000) - 32'h0010_0000;
  endfunction

  // Spare codes, loads of absent axes, clears and reloads inside a cell.
  task automatic send_noise_word();
    case ($urandom_range(3))
      0: begin
        send_word(OP_SPARE, AXIS_W'($urandom), $urandom, $urandom, $urandom);
      end
      1: begin
        send_word(OP_LOAD, AXIS_W'($urandom_range(3, DIMENSIONS)), $urandom, $urandom,
                  $urandom);
      end
      2: begin
        send_word(OP_CLEAR, AXIS_W'($urandom), $urandom, $urandom, $urandom);
      end
      default: begin
        send_word(OP_LOAD, AXIS_W'($urandom_range(DIMENSIONS - 1)), pick_q16(), pick_q16(),
                  $urandom);
      end
    endcase
  endtask

  // One cell with optional fresh intervals. Now and then the cell is cut short, which shifts
  // the coefficient position of the cells after it.
  task automatic send_random_cell();
    int n;
    int terms;
    for (n = 0; n < DIMENSIONS; n++) begin
      if ($urandom_range(9) < 4) begin
        send_word(OP_LOAD, AXIS_W'(n), pick_q16(), pick_q16(), $urandom);
      end
    end
    terms = ($urandom_range(19) == 0) ? $urandom_range(CELL_TERMS - 1, 1) : CELL_TERMS;
    for (n = 0; n < terms; n++) begin
      if ($urandom_range(99) < 8) begin
        send_noise_word();
      end
      send_word(OP_COEF, AXIS_W'($urandom), $urandom, $urandom, pick_q16());
    end
  endtask

  // Two directed cells. The first one loads the whole bound range on axis 0, whose cube
  // saturates, and reversed bounds on axis 1. Spare and out-of-range words and a reload
  // of axis 0 are mixed in, along with extreme coefficients. The second cell reuses the
  // moments of axis 1 without reloading them, so its overflow flag must be clear.
  task automatic test_directed_cells();
    send_word(OP_LOAD, 0, 32'h8000_0000, 32'h7FFF_FFFF, $urandom);
    send_word(OP_LOAD, 1, 1000 * 65536, -(1000 * 65536), $urandom);
    send_word(OP_COEF, 0, 0, 0, 32'h7FFF_FFFF);
    send_word(OP_SPARE, 3, 32'h8000_0000, 32'h7FFF_FFFF, $urandom);
    send_word(OP_COEF, 0, 0, 0, 32'h8000_0000);
    send_word(OP_LOAD, 2, 32'h7FFF_FFFF, 32'h8000_0000, $urandom);
    send_word(OP_LOAD, 0, 32'h0000_0000, Q_ONE, $urandom);
    send_word(OP_COEF, 0, 0, 0, 32'h0000_0000);
    send_word(OP_LOAD, 3, $urandom, $urandom, $urandom);
    send_word(OP_COEF, 0, 0, 0, 32'hFFFF_FFFF);
    send_word(OP_COEF, 0, 0, 0, 32'h0000_0001);
    send_word(OP_COEF, 0, 0, 0, Q_ONE);
    send_word(OP_COEF, 0, 0, 0, -Q_ONE);
    send_word(OP_COEF, 0, 0, 0, 32'h0000_8000);
    send_word(OP_COEF, 0, 0, 0, 32'h5555_AAAA);
    send_word(OP_COEF, 0, 0, 0, 32'h0000_1000);
    send_word(OP_COEF, 0, 0, 0, 32'hFFFF_F000);
    send_word(OP_COEF, 0, 0, 0, 32'h0000_0800);
    send_word(OP_CLEAR, 0, 0, 0, 0);
    send_word(OP_COEF, 0, 0, 0, 32'h0000_2000);
    send_word(OP_COEF, 0, 0, 0, 32'hFFFF_F800);
    send_word(OP_COEF, 0, 0, 0, 32'h0000_1800);
    send_word(OP_COEF, 0, 0, 0, 32'h0000_0400);
    send_word(OP_COEF, 0, 0, 0, 32'hFFFF_E000);
    send_word(OP_COEF, 0, 0, 0, 32'h0000_1000);
  endtask

  // The result side is held off for a long time while three cells are offered. The block
  // has to fill up and stop taking words.
  task automatic test_output_stall();
    int n;
    rx_hold = 1500;
    send_word(OP_LOAD, 0, pick_q16(), pick_q16(), $urandom);
    send_word(OP_LOAD, 1, pick_q16(), pick_q16(), $urandom);
    for (n = 0; n < 3 * CELL_TERMS; n++) begin
      send_word(OP_COEF, AXIS_W'($urandom), $urandom, $urandom, pick_q16());
    end
  endtask

  // Random cells with no idle cycles on either side.
  task automatic test_back_to_back();
    int n;
    idle_on = 1'b0;
    for (n = 0; n < 15; n++) begin
      send_random_cell();
    end
    idle_on = 1'b1;
  endtask

  // Random cells with idle cycles on both sides until enough words have gone in.
  task automatic test_random_cells();
    idle_on = 1'b1;
    while (words_sent < TARGET_WORDS) begin
      send_random_cell();
    end
  endtask

  initial begin
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_LOAD;
    axis = '0;
    lower_bound = '0;
    upper_bound = '0;
    coefficient = '0;
    idle_on = 1'b1;
    rx_hold = 0;
    mismatches = 0;
    integrals_checked = 0;
    words_sent = 0;
    words_ignored = 0;
    for (i = 0; i < NMOM; i++) begin
      moments[i] = 0;
    end
    for (i = 0; i < DIMENSIONS; i++) begin
      power_pos[i] = '0;
    end
    cell_sum = 0;
    mass_sum = 0;
    sat_seen = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_cells();
    test_output_stall();
    test_back_to_back();
    test_random_cells();

    // Let the last results come out, then allow for a stray word.
    in_valid <= 1'b0;
    while (pending_integrals.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d words, plus %0d with spare codes or absent axes; checked %0d cell integrals.",
             words_sent, words_ignored, integrals_checked);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Stop a run that hangs.
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
